### src/sfd_pkg.sv
// Shared types and constants of the SBUS frame decoder.
// Used by the unpack datapath, the top level and the testbench.
`timescale 1ns / 1ps

package sfd_pkg;

    // Frame layout.
    localparam logic [7:0] START_BYTE = 8'h0F;
    localparam int         POS_W      = 5;
    localparam int         NUM_CHAN   = 16;
    localparam int         CHAN_W     = 11;
    localparam int         IDX_W      = 4;
    localparam int         DATA_BYTES = 22;
    localparam int         DATA_W     = DATA_BYTES * 8;
    localparam int         FLAG_W     = 4;

    // Byte positions within a frame.
    localparam logic [POS_W-1:0] POS_HUNT = 5'd0;
    localparam logic [POS_W-1:0] POS_FLAG = 5'd23;
    localparam logic [POS_W-1:0] POS_END  = 5'd24;

    // Input item: one received serial byte.
    typedef struct packed {
        logic [7:0] rx_byte;
    } t_rx_item;

    // Result item: one proportional channel with the frame's flags.
    typedef struct packed {
        logic [IDX_W-1:0]  channel_index;
        logic [CHAN_W-1:0] channel_value;
        logic              digital_ch17;
        logic              digital_ch18;
        logic              frame_lost;
        logic              failsafe;
        logic              last;
    } t_result;

    // Controls from the sequencer to the unpack datapath.
    typedef struct packed {
        logic load_byte;
        logic load_flags;
        logic shift_chan;
    } t_unpack_ctrl;

endpackage

### src/sfd_stream_if.sv
// Valid/ready stream channel carrying one payload per transfer.
// The payload type is set by the instantiating scope (see sfd_pkg).
`timescale 1ns / 1ps

interface sfd_stream_if #(
    parameter type t_payload = logic [7:0]
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### src/sfd_unpack.sv
// Channel data shift chain of the SBUS frame decoder.
// One byte shifts in per load_byte cycle, one 11-bit channel out per shift_chan cycle.
`timescale 1ns / 1ps

module sfd_unpack (
    input  logic                         i_clk,
    input  sfd_pkg::t_unpack_ctrl        i_ctrl,
    input  logic [7:0]                   i_rx_byte,
    output logic [sfd_pkg::CHAN_W-1:0]   o_value,
    output logic [sfd_pkg::FLAG_W-1:0]   o_flags
);
    import sfd_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [FLAG_W-1:0] r_flags;

    // Data bytes enter at the top, so byte 1 ends at the low end, which makes
    // the little-endian packing line up with channel 0 in the low 11 bits.
    // While emitting, each cycle with shift_chan set drops one channel off the low end.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_byte) begin
            r_data <= {i_rx_byte, r_data[DATA_W-1:8]};
        end else if (i_ctrl.shift_chan) begin
            r_data <= {CHAN_W'(0), r_data[DATA_W-1:CHAN_W]};
        end
        if (i_ctrl.load_flags) begin
            r_flags <= i_rx_byte[7:4];
        end
    end

    assign o_value = r_data[CHAN_W-1:0];
    assign o_flags = r_flags;

endmodule

### src/sbus_frame_decoder_unit.sv
// SBUS frame decoder: hunts for the start byte, collects a 25-byte frame and
// emits 16 channel results. A new byte can transfer every cycle while collecting.
// After the end byte the input stalls while the results leave, one per cycle while
// the receiver takes them; the end byte transfer moves the sequencer to emitting,
// and each result is then set by the output register. Synchronous active-low
// reset returns to hunting with no result pending.
`timescale 1ns / 1ps

module sbus_frame_decoder_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sfd_stream_if.sink   i_byte,
    sfd_stream_if.source o_chan
);
    import sfd_pkg::*;

    typedef enum logic {
        S_COLLECT,
        S_EMIT
    } t_state;

    t_state             r_state;
    logic [POS_W-1:0]   r_pos;
    logic [IDX_W-1:0]   r_chan;
    logic               r_out_valid;
    t_result            r_out;

    t_unpack_ctrl       ctrl;
    logic               byte_xfer;
    logic               keep_byte;
    logic               out_free;
    logic [CHAN_W-1:0]  chan_value;
    logic [FLAG_W-1:0]  flags;
    logic [7:0]         rx_byte;

    assign rx_byte   = i_byte.payload.rx_byte;
    assign byte_xfer = i_byte.valid && i_byte.ready;
    // While hunting only the start byte opens a frame.
    assign keep_byte = byte_xfer && (r_pos != POS_HUNT || rx_byte == START_BYTE);
    assign out_free  = !r_out_valid || o_chan.ready;

    // Datapath controls: data bytes are positions 1 to 22.
    always_comb begin
        ctrl.load_byte  = keep_byte && r_pos != POS_HUNT && r_pos < POS_FLAG;
        ctrl.load_flags = keep_byte && r_pos == POS_FLAG;
        ctrl.shift_chan = (r_state == S_EMIT) && out_free;
    end

    sfd_unpack u_unpack (
        .i_clk     (i_clk),
        .i_ctrl    (ctrl),
        .i_rx_byte (rx_byte),
        .o_value   (chan_value),
        .o_flags   (flags)
    );

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_pos       <= POS_HUNT;
            r_chan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_COLLECT: begin
                    // The last result of a frame may still be waiting here.
                    if (o_chan.ready) begin
                        r_out_valid <= 1'b0;
                    end
                    if (keep_byte) begin
                        if (r_pos == POS_END) begin
                            r_pos   <= POS_HUNT;
                            r_chan  <= '0;
                            r_state <= S_EMIT;
                        end else begin
                            r_pos <= r_pos + POS_W'(1);
                        end
                    end
                end
                S_EMIT: begin
                    // A held result keeps its register until it transfers.
                    if (out_free) begin
                        r_out_valid         <= 1'b1;
                        r_out.channel_index <= r_chan;
                        r_out.channel_value <= chan_value;
                        r_out.digital_ch17  <= flags[3];
                        r_out.digital_ch18  <= flags[2];
                        r_out.frame_lost    <= flags[1];
                        r_out.failsafe      <= flags[0];
                        r_out.last          <= (r_chan == IDX_W'(NUM_CHAN - 1));
                        r_chan              <= r_chan + IDX_W'(1);
                        if (r_chan == IDX_W'(NUM_CHAN - 1)) begin
                            r_state <= S_COLLECT;
                        end
                    end
                end
                default: begin
                    r_state <= S_COLLECT;
                end
            endcase
        end
    end

    assign i_byte.ready   = (r_state == S_COLLECT);
    assign o_chan.valid   = r_out_valid;
    assign o_chan.payload = r_out;

endmodule

### tb/tb_sbus_frame_decoder_unit.sv
// Self-checking testbench for sbus_frame_decoder_unit: drives received bytes,
// predicts the 16 channel results of each frame and checks them in order.
// Depends on sfd_pkg and sfd_stream_if from the source folder.
`timescale 1ns / 1ps

module tb_sbus_frame_decoder_unit;

    import sfd_pkg::*;

    localparam int FRAME_LEN        = POS_END + 1;
    localparam int DRAIN_CYCLES     = 24;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT       = 2000;
    localparam int RANDOM_FRAMES    = 3;

    // Receiver stall styles, each held for a window of cycles.
    typedef enum int {
        RX_FREE,
        RX_RANDOM,
        RX_SPARSE
    } t_rx_style;

    // Frame tracker: rebuilds each frame and keeps the channel results owed.
    class sbus_frame_tracker;
        logic [7:0]       frame_store [0:POS_END-1];
        logic [POS_W-1:0] byte_pos;
        t_result          owed_channels [$];
        int unsigned      mismatch_count;
        int unsigned      frames_decoded;
        int unsigned      channels_checked;

        function new();
            byte_pos         = POS_HUNT;
            mismatch_count   = 0;
            frames_decoded   = 0;
            channels_checked = 0;
        endfunction

        function int unsigned pending();
            return owed_channels.size();
        endfunction

        // Notes one accepted byte; the 25th byte of a frame releases 16 results.
        function void absorb_byte(logic [7:0] rx_value);
            logic [DATA_W-1:0] packed_data;
            logic [7:0]        flags;
            t_result           chan;
            int                i;
            if (byte_pos == POS_HUNT && rx_value != START_BYTE) begin
                return;
            end
            if (byte_pos < POS_END) begin
                frame_store[byte_pos] = rx_value;
            end
            if (byte_pos != POS_END) begin
                byte_pos = byte_pos + 1'b1;
                return;
            end
            byte_pos = POS_HUNT;
            frames_decoded++;
            for (i = 1; i <= DATA_BYTES; i++) begin
                packed_data[8*(i-1) +: 8] = frame_store[i];
            end
            flags = frame_store[POS_FLAG];
            for (i = 0; i < NUM_CHAN; i++) begin
                chan.channel_index = i[IDX_W-1:0];
                chan.channel_value = packed_data[CHAN_W*i +: CHAN_W];
                chan.digital_ch17  = flags[7];
                chan.digital_ch18  = flags[6];
                chan.frame_lost    = flags[5];
                chan.failsafe      = flags[4];
                chan.last          = (i == NUM_CHAN - 1);
                owed_channels.push_back(chan);
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatch_count++;
            end
        endfunction

        // Checks one accepted result against the oldest owed channel.
        function void check_channel(t_result got);
            t_result want;
            if (owed_channels.size() == 0) begin
                $error("channel result with none owed: index %0d value %0d",
                       got.channel_index, got.channel_value);
                mismatch_count++;
                return;
            end
            want = owed_channels.pop_front();
            channels_checked++;
            compare_field("channel_index", 32'(want.channel_index),
                          32'(got.channel_index));
            compare_field("channel_value", 32'(want.channel_value),
                          32'(got.channel_value));
            compare_field("digital_ch17", 32'(want.digital_ch17), 32'(got.digital_ch17));
            compare_field("digital_ch18", 32'(want.digital_ch18), 32'(got.digital_ch18));
            compare_field("frame_lost", 32'(want.frame_lost), 32'(got.frame_lost));
            compare_field("failsafe", 32'(want.failsafe), 32'(got.failsafe));
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    sfd_stream_if #(.t_payload(t_rx_item)) byte_if ();
    sfd_stream_if #(.t_payload(t_result))  chan_if ();

    sbus_frame_tracker tracker = new();

    int unsigned bytes_accepted;
    int unsigned idle_cycles;
    int unsigned burst_left;
    bit          long_hold_req;
    bit          long_hold_done;

    sbus_frame_decoder_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_if),
        .o_chan  (chan_if)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // Transfer monitor, result checking and the no-progress watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (byte_if.valid && byte_if.ready) begin
                tracker.absorb_byte(byte_if.payload.rx_byte);
                bytes_accepted++;
            end
            if (chan_if.valid && chan_if.ready) begin
                tracker.check_channel(chan_if.payload);
            end
            if ((byte_if.valid && byte_if.ready) || (chan_if.valid && chan_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles.", IDLE_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Result receiver: windows of free flow, random stalls and sparse ready,
    // with one long hold-off on request.
    initial begin
        t_rx_style   style;
        int unsigned win_cnt;
        chan_if.ready <= 1'b0;
        style   = RX_FREE;
        win_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                chan_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                long_hold_req  = 1'b0;
                long_hold_done = 1'b1;
            end else begin
                if (win_cnt % 24 == 0) begin
                    style = t_rx_style'($urandom_range(RX_FREE, RX_SPARSE));
                end
                win_cnt++;
                case (style)
                    RX_FREE: begin
                        chan_if.ready <= 1'b1;
                    end
                    RX_RANDOM: begin
                        chan_if.ready <= ($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        chan_if.ready <= (win_cnt % 3 == 0);
                    end
                endcase
            end
        end
    end

    // Offers one byte, waits for its transfer, then applies the burst pacing.
    task automatic send_byte(input logic [7:0] rx_value);
        byte_if.payload.rx_byte <= rx_value;
        byte_if.valid           <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!byte_if.ready);
        if (burst_left == 0) begin
            byte_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 30);
        end else begin
            burst_left--;
        end
    endtask

    // Holds the input idle until every owed result has arrived, then lets the
    // pipeline settle.
    task automatic drain_results();
        byte_if.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // A byte that the hunting state drops.
    task automatic send_noise();
        logic [7:0] rx_value;
        rx_value = 8'($urandom_range(0, 255));
        if (rx_value == START_BYTE) begin
            rx_value = rx_value ^ 8'h80;
        end
        send_byte(rx_value);
    endtask

    // One well-formed frame with random channel data, flags and end byte.
    task automatic send_random_frame();
        logic [7:0] rx_value;
        int         i;
        send_byte(START_BYTE);
        for (i = 1; i < FRAME_LEN; i++) begin
            case ($urandom_range(0, 7))
                0: rx_value = 8'h00;
                1: rx_value = 8'hFF;
                2: rx_value = START_BYTE;
                default: rx_value = 8'($urandom_range(0, 255));
            endcase
            send_byte(rx_value);
        end
    endtask

    // Stimulus sequence.
    initial begin
        int i;
        int n;
        i_rst_n              <= 1'b0;
        byte_if.valid        <= 1'b0;
        byte_if.payload      <= '0;
        bytes_accepted        = 0;
        idle_cycles           = 0;
        burst_left            = 0;
        long_hold_req         = 1'b0;
        long_hold_done        = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Bytes dropped while hunting, including the start value off by one.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(START_BYTE - 1'b1);

        // Directed frame: full-scale channels 0 to 7, a start value as data,
        // zero channels after it, all flags set, and a start value as end byte.
        send_byte(START_BYTE);
        for (i = 1; i <= 11; i++) begin
            send_byte(8'hFF);
        end
        send_byte(START_BYTE);
        for (i = 13; i <= DATA_BYTES; i++) begin
            send_byte(8'h00);
        end
        send_byte(8'hF0);
        send_byte(START_BYTE);
        drain_results();

        // Random frames with noise between them. The second frame starts a long
        // receiver hold-off so the third frame backs up into the input.
        for (i = 0; i < RANDOM_FRAMES; i++) begin
            n = $urandom_range(0, 3);
            repeat (n) send_noise();
            if (i == 1) begin
                long_hold_req = 1'b1;
            end
            send_random_frame();
        end
        drain_results();

        // A partial frame at the end owes nothing.
        send_noise();
        send_byte(START_BYTE);
        repeat (3) send_byte(8'($urandom_range(0, 255)));
        drain_results();

        $display("Covered %0d byte transfers, %0d frames and %0d channel results,",
                 bytes_accepted, tracker.frames_decoded, tracker.channels_checked);
        $display("with hunting noise, burst pacing and a long receiver hold-off (%0s).",
                 long_hold_done ? "done" : "missed");
        if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
src/sfd_pkg.sv
src/sfd_stream_if.sv
src/sfd_unpack.sv
src/sbus_frame_decoder_unit.sv
tb/tb_sbus_frame_decoder_unit.sv
